// ===== design/tccs_pkg.sv =====
// Package for the text console engine: default geometry, character codes,
// function codes and the request and response structures.
// Depends on nothing; used by the console top level, not by tccs_ram.
package tccs_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Control characters that move the cursor without writing a cell.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    // Function codes carried in a request.
    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } req_t;

    // One response as it leaves on the output channel.
    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } rsp_t;

endpackage

// ===== design/tccs_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; instanced by the console top level for the cell store.
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/text_console_cursor_scroll.sv =====
// Top level of the text console engine: cursor, sequencer and cell store.
// Depends on tccs_pkg and tccs_ram.
//
//   Channel | Signals                       | Direction | Payload
//   request | req_valid, req_ready, req_data | in        | tccs_pkg::req_t
//   response| rsp_valid, rsp_ready, rsp_data | out       | tccs_pkg::rsp_t
//
// A put without scrolling, a read and an unused function pass from idle to the finish state.
// A put that scrolls passes through the scroll state: the store is copied up
// one row, one cell per cycle through the single write port of the RAM.
// A clear passes through the clearing state, one cell zeroed per cycle.
// After reset a clearing pass over every cell runs before req_ready.
// A request is taken while a response still waits; the next response then
// holds in the sequencer until the output register is free.
module text_console_cursor_scroll #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tccs_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tccs_pkg::rsp_t rsp_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic           clr_rsp_reg, clr_rsp_next;
    logic           pend_valid_reg, pend_valid_next;
    logic           pend_copy_reg, pend_copy_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic           hit_reg, hit_next;
    logic           scroll_reg, scroll_next;
    logic           rsp_valid_reg, rsp_valid_next;
    tccs_pkg::rsp_t rsp_reg, rsp_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    logic              req_fire;
    logic              is_nl;
    logic              is_cr;
    logic              is_print;
    logic              wrap;
    logic              new_line;
    logic              at_bottom;
    logic              rd_hit;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;

    // Cell store.
    tccs_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Decode of the incoming character against the present cursor.
    assign is_nl     = (req_data.char_code == tccs_pkg::CH_NEWLINE);
    assign is_cr     = (req_data.char_code == tccs_pkg::CH_RETURN);
    assign is_print  = !is_nl && !is_cr;
    assign wrap      = is_print && (cur_col_reg == LAST_COL);
    assign new_line  = is_nl || wrap;
    assign at_bottom = (cur_row_reg == LAST_ROW);

    // Cell addresses for the cursor and for a read request.
    assign cur_addr = ADDR_W'(cur_row_reg * COLUMNS + cur_col_reg);
    assign rd_hit   = (req_data.read_row < ROWS) && (req_data.read_col < COLUMNS);
    assign rd_addr  = ADDR_W'(req_data.read_row * COLUMNS + req_data.read_col);

    // Sequencer and memory port control.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        clr_rsp_next    = clr_rsp_reg;
        pend_valid_next = 1'b0;
        pend_copy_next  = pend_copy_reg;
        pend_addr_next  = pend_addr_reg;
        hit_next        = hit_reg;
        scroll_next     = scroll_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = rd_addr;

        // A row-copy write lands in the cycle after its read was issued.
        if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_copy_reg ? ram_rdata : 16'h0000;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = 16'h0000;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next     = '0;
                    clr_rsp_next = 1'b0;
                    state_next   = clr_rsp_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    hit_next    = 1'b0;
                    scroll_next = 1'b0;
                    state_next  = ST_FINISH;
                    case (req_data.func)
                        tccs_pkg::FUNC_PUT:
                        begin
                            if (is_print)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = cur_addr;
                                ram_wdata    = {req_data.color, req_data.char_code};
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                            if (is_cr || new_line)
                            begin
                                cur_col_next = '0;
                            end
                            if (new_line && !at_bottom)
                            begin
                                cur_row_next = cur_row_reg + 1'b1;
                            end
                            if (new_line && at_bottom)
                            begin
                                scroll_next = 1'b1;
                                cnt_next    = '0;
                                state_next  = ST_SCROLL;
                            end
                        end
                        tccs_pkg::FUNC_READ:
                        begin
                            hit_next  = rd_hit;
                            ram_re    = rd_hit;
                            ram_raddr = rd_addr;
                        end
                        tccs_pkg::FUNC_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            clr_rsp_next = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // Read one row below, write back here next cycle; bottom row zeroed.
                pend_valid_next = 1'b1;
                pend_addr_next  = cnt_reg;
                pend_copy_next  = (cnt_reg < COPY_END);
                if (cnt_reg < COPY_END)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg + ROW_STEP;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.cell_value = hit_reg ? ram_rdata : 16'h0000;
                    rsp_next.cursor_col = 7'(cur_col_reg);
                    rsp_next.cursor_row = 5'(cur_row_reg);
                    rsp_next.scrolled   = scroll_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            clr_rsp_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            clr_rsp_reg    <= clr_rsp_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_copy_reg <= pend_copy_next;
        pend_addr_reg <= pend_addr_next;
        hit_reg       <= hit_next;
        scroll_reg    <= scroll_next;
        rsp_reg       <= rsp_next;
    end

    // The cursor always stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= LAST_ROW) && (cur_col_reg <= LAST_COL))
        else $error("cursor left the screen");

    // A pending row-copy write only exists during or just after a scroll.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCROLL) || (state_reg == ST_FINISH))
        else $error("row-copy write outside a scroll");

    // The final scroll step writes a blank cell and hands over to the response.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) && (cnt_reg == LAST_ADDR)
        |=> (state_reg == ST_FINISH) && pend_valid_reg && !pend_copy_reg)
        else $error("scroll did not end on a blank bottom cell");

    // A response that reports a scroll leaves the cursor at the start of the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.scrolled
        |-> (rsp_reg.cursor_col == 7'd0) && (rsp_reg.cursor_row == 5'(LAST_ROW)))
        else $error("scroll reported with cursor off the last row start");

endmodule
